@@ src/scdmr_pkg.sv @@
package scdmr_pkg;

  localparam int DUTY_W = 8;
  localparam int CHAR_W = 8;
  localparam int MODE_W = 3;
  localparam int CFG_IDX_W = 2;

  // Item kinds on the input stream.
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FULL_DUTY = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HALF_DUTY = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RAMP_STEP = 2'd2;

  localparam logic [DUTY_W-1:0] FULL_DUTY_RST = 8'h32;
  localparam logic [DUTY_W-1:0] HALF_DUTY_RST = 8'h19;
  localparam logic [DUTY_W-1:0] RAMP_STEP_RST = 8'd1;

  // Drive modes.
  localparam logic [MODE_W-1:0] MODE_START     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_SLOW_STOP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RIGHT     = 3'd2;
  localparam logic [MODE_W-1:0] MODE_RIGHT_FWD = 3'd3;
  localparam logic [MODE_W-1:0] MODE_LEFT      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_LEFT_FWD  = 3'd5;
  localparam logic [MODE_W-1:0] MODE_FWD       = 3'd6;
  localparam logic [MODE_W-1:0] MODE_REVERSE   = 3'd7;

  localparam logic [CHAR_W-1:0] CHAR_START = 8'd115;
  localparam logic [CHAR_W-1:0] CHAR_END   = 8'd101;

  typedef struct packed {
    logic [DUTY_W-1:0] full_duty;
    logic [DUTY_W-1:0] half_duty;
    logic [DUTY_W-1:0] ramp_step;
  } cfg_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [MODE_W-1:0] mode_nxt;
    logic              stop_ack;
  } parse_stat_t;

  typedef struct packed {
    logic              hit;
    logic [MODE_W-1:0] mode;
  } code_t;

  function automatic code_t decode_code(input logic [CHAR_W-1:0] hi,
                                        input logic [CHAR_W-1:0] lo);
    code_t res;
    res.hit  = 1'b0;
    res.mode = MODE_START;
    if (hi == "0") begin
      case (lo)
        "0": begin res.hit = 1'b1; res.mode = MODE_START; end
        "2": begin res.hit = 1'b1; res.mode = MODE_SLOW_STOP; end
        default: res.hit = 1'b0;
      endcase
    end else if (hi == "1") begin
      case (lo)
        "2": begin res.hit = 1'b1; res.mode = MODE_RIGHT; end
        "A": begin res.hit = 1'b1; res.mode = MODE_RIGHT_FWD; end
        "1": begin res.hit = 1'b1; res.mode = MODE_LEFT; end
        "9": begin res.hit = 1'b1; res.mode = MODE_LEFT_FWD; end
        "8": begin res.hit = 1'b1; res.mode = MODE_FWD; end
        "4": begin res.hit = 1'b1; res.mode = MODE_REVERSE; end
        default: res.hit = 1'b0;
      endcase
    end
    return res;
  endfunction

  // One ramp step toward goal; never passes the goal.
  function automatic logic [DUTY_W-1:0] ramp_toward(input logic [DUTY_W-1:0] cur,
                                                    input logic [DUTY_W-1:0] goal,
                                                    input logic [DUTY_W-1:0] step);
    logic [DUTY_W-1:0] res;
    res = cur;
    if (goal > cur) begin
      res = ((goal - cur) <= step) ? goal : cur + step;
    end else if (goal < cur) begin
      res = ((cur - goal) <= step) ? goal : cur - step;
    end
    return res;
  endfunction

endpackage

@@ src/scdmr_parser.sv @@
module scdmr_parser
  import scdmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              opcode,
  input  logic [CHAR_W-1:0] rx_byte,
  output parse_stat_t       stat
);

  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_HIGH = 2'd1;
  localparam logic [1:0] PH_LOW  = 2'd2;
  localparam logic [1:0] PH_END  = 2'd3;

  logic [1:0]        phase_r, phase_nxt;
  logic [CHAR_W-1:0] code_high_r, code_high_nxt;
  logic [CHAR_W-1:0] code_low_r, code_low_nxt;
  logic [MODE_W-1:0] mode_r, mode_nxt;
  logic              ack;
  code_t             dec;

  assign dec = decode_code(code_high_r, code_low_r);

  always_comb begin
    phase_nxt     = phase_r;
    code_high_nxt = code_high_r;
    code_low_nxt  = code_low_r;
    mode_nxt      = mode_r;
    ack           = 1'b0;
    if (opcode == OP_BYTE) begin
      unique case (phase_r)
        PH_WAIT: begin
          if (rx_byte == CHAR_START) phase_nxt = PH_HIGH;
        end
        PH_HIGH: begin
          code_high_nxt = rx_byte;
          phase_nxt     = PH_LOW;
        end
        PH_LOW: begin
          code_low_nxt = rx_byte;
          phase_nxt    = PH_END;
        end
        default: begin
          // A bad closing byte or an unknown code drops the frame quietly.
          if (rx_byte == CHAR_END && dec.hit) begin
            mode_nxt = dec.mode;
            ack      = (dec.mode == MODE_SLOW_STOP);
          end
          phase_nxt = PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT;
      code_high_r <= '0;
      code_low_r  <= '0;
      mode_r      <= MODE_START;
    end else if (adv) begin
      phase_r     <= phase_nxt;
      code_high_r <= code_high_nxt;
      code_low_r  <= code_low_nxt;
      mode_r      <= mode_nxt;
    end
  end

  assign stat.mode     = mode_r;
  assign stat.mode_nxt = mode_nxt;
  assign stat.stop_ack = ack;

endmodule

@@ src/scdmr_ramp.sv @@
module scdmr_ramp
  import scdmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              opcode,
  input  logic [MODE_W-1:0] mode,
  input  cfg_t              cfg,
  output logic [DUTY_W-1:0] left_nxt,
  output logic [DUTY_W-1:0] right_nxt
);

  logic [DUTY_W-1:0] left_r, right_r;
  logic [DUTY_W-1:0] goal_l, goal_r;
  logic              hold;

  always_comb begin
    goal_l = '0;
    goal_r = '0;
    hold   = 1'b0;
    unique case (mode)
      MODE_RIGHT:     begin goal_l = cfg.full_duty; goal_r = '0; end
      MODE_RIGHT_FWD: begin goal_l = cfg.full_duty; goal_r = cfg.half_duty; end
      MODE_LEFT:      begin goal_l = '0;            goal_r = cfg.full_duty; end
      MODE_LEFT_FWD:  begin goal_l = cfg.half_duty; goal_r = cfg.full_duty; end
      MODE_FWD:       begin goal_l = cfg.full_duty; goal_r = cfg.full_duty; end
      MODE_REVERSE:   hold = 1'b1;
      default:        begin goal_l = '0; goal_r = '0; end
    endcase
  end

  always_comb begin
    left_nxt  = left_r;
    right_nxt = right_r;
    if (opcode == OP_TICK && !hold) begin
      left_nxt  = ramp_toward(left_r, goal_l, cfg.ramp_step);
      right_nxt = ramp_toward(right_r, goal_r, cfg.ramp_step);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r  <= '0;
      right_r <= '0;
    end else if (adv) begin
      left_r  <= left_nxt;
      right_r <= right_nxt;
    end
  end

endmodule

@@ src/serial_command_dual_motor_ramp.sv @@
// Path: an accepted request is held in the input register, then its result is written
// to the result register, from which it is presented.
// Throughput: one request per cycle while out_tready keeps up; input refills while a result waits.
// Reset (rst_n low, synchronous): frame parser waits for a start byte, mode is start,
// both duties are zero, and the duty registers return to 50, 25 and a step of 1.
module serial_command_dual_motor_ramp
  import scdmr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [7:0] rx_byte
  input  logic                 in_tuser,   // [0] opcode
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [23:0]          out_tdata,  // [7:0] left_duty, [15:8] right_duty,
                                           // [18:16] drive_mode, [23:19] zero
  output logic                 out_tuser,  // [0] stop_ack
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DUTY_W-1:0]    cfg_data
);

  cfg_t              cfg_r;
  logic              s1_valid_r;
  logic              s1_op_r;
  logic [CHAR_W-1:0] s1_byte_r;
  logic              adv;
  logic              out_free;
  parse_stat_t       pstat;
  logic [DUTY_W-1:0] left_nxt, right_nxt;
  logic              out_valid_r;
  logic [DUTY_W-1:0] out_left_r, out_right_r;
  logic [MODE_W-1:0] out_mode_r;
  logic              out_ack_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.full_duty <= FULL_DUTY_RST;
      cfg_r.half_duty <= HALF_DUTY_RST;
      cfg_r.ramp_step <= RAMP_STEP_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FULL_DUTY: cfg_r.full_duty <= cfg_data;
        REG_HALF_DUTY: cfg_r.half_duty <= cfg_data;
        REG_RAMP_STEP: cfg_r.ramp_step <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_free  = !out_valid_r || out_tready;
  assign adv       = s1_valid_r && out_free;
  assign in_tready = !s1_valid_r || out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r   <= in_tuser;
      s1_byte_r <= in_tdata;
    end
  end

  scdmr_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .opcode  (s1_op_r),
    .rx_byte (s1_byte_r),
    .stat    (pstat)
  );

  // Ticks and bytes never share an item, so the tick uses the settled mode.
  scdmr_ramp u_ramp (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .opcode    (s1_op_r),
    .mode      (pstat.mode),
    .cfg       (cfg_r),
    .left_nxt  (left_nxt),
    .right_nxt (right_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_left_r  <= left_nxt;
      out_right_r <= right_nxt;
      out_mode_r  <= pstat.mode_nxt;
      out_ack_r   <= pstat.stop_ack;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, out_mode_r, out_right_r, out_left_r};
  assign out_tuser  = out_ack_r;

endmodule
